/* hdl/pse_pkg.sv */
`timescale 1ns / 1ps

package pse_pkg;

    localparam int WORD_W           = 32;
    localparam int COUNT_W          = 7;
    localparam int FIELD_W          = 6;
    localparam int COUNT_MAX        = 127;
    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int M_TDATA_W        = 16;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd52;
    localparam logic [COUNT_W-1:0] COUNT_MIN   = 7'd2;

endpackage

/* hdl/pse_divider.sv */
`timescale 1ns / 1ps

module pse_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [pse_pkg::WORD_W-1:0]   dividend,
    input  logic [pse_pkg::COUNT_W-1:0]  divisor,
    output logic                         done,
    output logic [pse_pkg::COUNT_W-1:0]  remainder
);
    import pse_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic [WORD_W-1:0]  word_reg, word_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [COUNT_W-1:0] div_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [COUNT_W:0]   trial;

    // One restoring step per cycle: bring in the next dividend bit, subtract if it fits.
    always_comb begin
        trial     = {rem_reg, word_reg[WORD_W-1]};
        word_next = {word_reg[WORD_W-2:0], 1'b0};
        if (trial >= {1'b0, div_reg}) begin
            rem_next = COUNT_W'(trial - {1'b0, div_reg});
        end else begin
            rem_next = trial[COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(WORD_W - 1);
                word_reg <= dividend;
                div_reg  <= divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                word_reg <= word_next;
                rem_reg  <= rem_next;
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* hdl/pse_perm_store.sv */
`timescale 1ns / 1ps

module pse_perm_store #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         clear,
    input  logic                         wr_en,
    input  logic [IDX_W-1:0]             wr_addr,
    input  logic [pse_pkg::FIELD_W-1:0]  wr_data,
    input  logic [IDX_W-1:0]             rd_addr,
    output logic [pse_pkg::FIELD_W-1:0]  rd_data
);
    import pse_pkg::*;

    logic [FIELD_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [FIELD_W-1:0] rd_mem_reg;
    logic               rd_valid_reg;
    logic [IDX_W-1:0]   rd_addr_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_mem_reg  <= mem[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // An entry not written since the last restart holds its own index.
    assign rd_data = rd_valid_reg ? rd_mem_reg : FIELD_W'(rd_addr_reg);

endmodule

/* hdl/permutation_shuffle_engine.sv */
`timescale 1ns / 1ps
// Each input transfer passes through the bit-serial remainder unit (S_DIV), the store states
// S_RD_I, S_RD_J, S_WR_I and S_WR_J and the output register (S_PUT1) before its first result;
// the final result of a run follows through S_RD_L and S_PUT2.
// A new input item is taken only in S_IDLE, once the previous step is through: the shared
// remainder unit and the single read port of the permutation store serve every step.
// Reset (aresetn low, synchronous): element count 52, store back to identity, step zero.

module permutation_shuffle_engine #(
    parameter int MAX_ELEMENTS = pse_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pse_pkg::COUNT_W-1:0]     cfg_element_count,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pse_pkg::WORD_W-1:0]      s_tdata,   // [31:0] random_word
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pse_pkg::M_TDATA_W-1:0]   m_tdata,   // [5:0] position, [11:6] element
    output logic                            m_tlast    // last
);
    import pse_pkg::*;

    localparam int STORE_DEPTH = (MAX_ELEMENTS > COUNT_MAX) ? COUNT_MAX : MAX_ELEMENTS;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam logic [COUNT_W-1:0] N_CAP = COUNT_W'(STORE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_RD_I,
        S_RD_J,
        S_WR_I,
        S_WR_J,
        S_PUT1,
        S_RD_L,
        S_PUT2
    } state_t;

    state_t              state_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]    step_reg, step_next;
    logic [IDX_W-1:0]    j_reg;
    logic [FIELD_W-1:0]  vi_reg;
    logic [FIELD_W-1:0]  vj_reg;
    logic                m_tvalid_reg;
    logic [FIELD_W-1:0]  m_pos_reg;
    logic [FIELD_W-1:0]  m_elem_reg;
    logic                m_last_reg;

    logic [COUNT_W-1:0]  n_eff;
    logic [COUNT_W-1:0]  step_ext;
    logic                in_range;
    logic                final_step;
    logic [COUNT_W-1:0]  span;
    logic [IDX_W-1:0]    last_addr;
    logic                accept;
    logic                out_free;
    logic                out_load;
    logic                div_done;
    logic [COUNT_W-1:0]  div_rem;
    logic                st_clear;
    logic                st_wr_en;
    logic [IDX_W-1:0]    st_wr_addr;
    logic [FIELD_W-1:0]  st_wr_data;
    logic [IDX_W-1:0]    st_rd_addr;
    logic [FIELD_W-1:0]  st_rd_data;

    always_comb begin
        if (count_reg < COUNT_MIN) begin
            n_eff = COUNT_MIN;
        end else if (count_reg > N_CAP) begin
            n_eff = N_CAP;
        end else begin
            n_eff = count_reg;
        end
    end

    assign step_ext   = COUNT_W'(step_reg);
    assign in_range   = (step_ext <= n_eff - COUNT_MIN);
    assign final_step = (step_ext == n_eff - COUNT_MIN);
    // A step counter beyond the run restarts it at position zero.
    assign span       = in_range ? (n_eff - step_ext) : n_eff;
    assign last_addr  = IDX_W'(n_eff - 1'b1);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign out_load   = ((state_reg == S_PUT1) || (state_reg == S_PUT2)) && out_free;
    assign s_tready   = (state_reg == S_IDLE);

    pse_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .dividend  (s_tdata),
        .divisor   (span),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb begin
        st_wr_en   = 1'b0;
        st_wr_addr = step_reg;
        st_wr_data = st_rd_data;
        st_rd_addr = step_reg;
        case (state_reg)
            S_RD_J: begin
                st_rd_addr = j_reg;
            end
            S_WR_I: begin
                st_wr_en = 1'b1;
            end
            S_WR_J: begin
                st_wr_en   = 1'b1;
                st_wr_addr = j_reg;
                st_wr_data = vi_reg;
            end
            S_RD_L, S_PUT2: begin
                st_rd_addr = last_addr;
            end
            default: begin
                st_rd_addr = step_reg;
            end
        endcase
    end

    always_comb begin
        step_next = step_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && !in_range) begin
                    step_next = '0;
                end
            end
            S_PUT1: begin
                if (out_free && !final_step) begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_PUT2: begin
                if (out_free) begin
                    step_next = '0;
                end
            end
            default: begin
                step_next = step_reg;
            end
        endcase
        // A new element count starts a fresh run.
        if (cfg_wr_en) begin
            step_next = '0;
        end
    end

    assign st_clear = cfg_wr_en || (accept && !in_range) ||
                      ((state_reg == S_PUT2) && out_free);

    pse_perm_store #(
        .DEPTH (STORE_DEPTH),
        .IDX_W (IDX_W)
    ) u_perm_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (st_clear),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= COUNT_RESET;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        j_reg     <= IDX_W'(COUNT_W'(step_ext + div_rem));
                        state_reg <= S_RD_I;
                    end
                end
                S_RD_I: begin
                    state_reg <= S_RD_J;
                end
                S_RD_J: begin
                    vi_reg    <= st_rd_data;
                    state_reg <= S_WR_I;
                end
                S_WR_I: begin
                    vj_reg    <= st_rd_data;
                    state_reg <= S_WR_J;
                end
                S_WR_J: begin
                    state_reg <= S_PUT1;
                end
                S_PUT1: begin
                    if (out_free) begin
                        m_pos_reg  <= FIELD_W'(step_reg);
                        m_elem_reg <= vj_reg;
                        m_last_reg <= 1'b0;
                        if (final_step) begin
                            state_reg <= S_RD_L;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_RD_L: begin
                    state_reg <= S_PUT2;
                end
                S_PUT2: begin
                    if (out_free) begin
                        m_pos_reg  <= FIELD_W'(last_addr);
                        m_elem_reg <= st_rd_data;
                        m_last_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (cfg_wr_en) begin
                count_reg <= cfg_element_count;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - 2 * FIELD_W){1'b0}}, m_elem_reg, m_pos_reg};
    assign m_tlast  = m_last_reg;

endmodule

/* hdl/pse_checker.sv */
`timescale 1ns / 1ps

module pse_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [pse_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            m_tlast
);
    import pse_pkg::*;

    // Reset leaves no result pending and the input side open.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result pending or input closed after reset");

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a step is in progress");

    // Padding above the element field is always zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:2*FIELD_W] == '0)
        else $error("nonzero padding in result data");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind permutation_shuffle_engine pse_checker u_pse_checker (.*);

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import pse_pkg::*;

    localparam int SHUFFLE_SIZE = MAX_ELEMENTS_DEF;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic [FIELD_W-1:0] position;
        logic [FIELD_W-1:0] element;
        logic               last;
    } placement_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [COUNT_W-1:0]   cfg_element_count;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [WORD_W-1:0]    s_tdata;      // [31:0] random_word
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;      // [5:0] position, [11:6] element
    logic                 m_tlast;      // last

    // Software copy of the shuffle state.
    logic [FIELD_W-1:0] order_model [0:SHUFFLE_SIZE-1];
    int unsigned        step_model;
    logic [COUNT_W-1:0] count_model;

    placement_t  expected_placements[$];
    int unsigned mismatch_count;
    int unsigned items_sent;
    int unsigned burst_left;
    int unsigned idle_cycles;

    permutation_shuffle_engine #(
        .MAX_ELEMENTS(SHUFFLE_SIZE)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_element_count (cfg_element_count),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tlast           (m_tlast)
    );

    always #10 aclk = ~aclk;

    function automatic int unsigned active_count();
        int unsigned n;
        n = count_model;
        if (n < COUNT_MIN)
            n = COUNT_MIN;
        if (n > SHUFFLE_SIZE)
            n = SHUFFLE_SIZE;
        return n;
    endfunction

    function automatic void restart_order();
        for (int k = 0; k < SHUFFLE_SIZE; k++)
            order_model[k] = k[FIELD_W-1:0];
        step_model = 0;
    endfunction

    // One Fisher-Yates step: swap position i with i + word mod (n - i).
    function automatic void shuffle_step(input logic [WORD_W-1:0] word);
        int unsigned        n;
        int unsigned        i;
        int unsigned        partner;
        logic [FIELD_W-1:0] held;
        placement_t         p;
        n = active_count();
        i = step_model;
        if (i > n - 2) begin
            restart_order();
            i = 0;
        end
        partner = i + (word % (n - i));
        held = order_model[partner];
        order_model[partner] = order_model[i];
        order_model[i] = held;
        p.position = i[FIELD_W-1:0];
        p.element  = order_model[i];
        p.last     = 1'b0;
        expected_placements.push_back(p);
        if (i == n - 2) begin
            p.position = FIELD_W'(n - 1);
            p.element  = order_model[n-1];
            p.last     = 1'b1;
            expected_placements.push_back(p);
            restart_order();
        end else begin
            step_model = i + 1;
        end
    endfunction

    function automatic void report_failure(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $time, what);
    endfunction

    always @(posedge aclk) begin : check_results
        placement_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_placements.size() == 0) begin
                report_failure($sformatf("unexpected result pos=%0d elem=%0d last=%0b",
                    m_tdata[5:0], m_tdata[11:6], m_tlast));
            end else begin
                want = expected_placements.pop_front();
                if (m_tdata[5:0] !== want.position || m_tdata[11:6] !== want.element
                        || m_tlast !== want.last)
                    report_failure($sformatf(
                        "expected pos=%0d elem=%0d last=%0b, got pos=%0d elem=%0d last=%0b",
                        want.position, want.element, want.last,
                        m_tdata[5:0], m_tdata[11:6], m_tlast));
            end
        end
    end

    // Receiver back-pressure changes character every stretch of cycles.
    always @(negedge aclk) begin : drive_ready
        int unsigned stretch_left;
        int unsigned mode;
        if (stretch_left == 0) begin
            stretch_left = $urandom_range(20, 200);
            mode = $urandom_range(0, 3);
        end
        stretch_left--;
        case (mode)
            0: m_tready = 1'b1;
            1: m_tready = 1'($urandom_range(0, 1));
            2: m_tready = ($urandom_range(0, 3) == 0);
            default: m_tready = ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_word(input logic [WORD_W-1:0] word);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = word;
        do @(posedge aclk); while (!s_tready);
        shuffle_step(word);
        items_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_placements.size() != 0)
            @(posedge aclk);
        // Let the final store cycles of the run settle before anything else.
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_element_count(input logic [COUNT_W-1:0] value);
        wait_for_results();
        @(negedge aclk);
        cfg_wr_en         = 1'b1;
        cfg_element_count = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        count_model = value;
        restart_order();
    endtask

    // A few steps at the reset count, then a write in the middle of the run.
    task automatic test_reset_count();
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'h8000_0001);
        set_element_count(7'd0);
    endtask

    // Counts of 0 and 1 behave as 2; each step then closes a run. Counts of 2 and 3 follow.
    task automatic test_small_counts();
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        set_element_count(7'd1);
        send_word(32'h0000_0001);
        send_word(32'h0000_0002);
        set_element_count(7'd2);
        send_word(32'h0000_0003);
        set_element_count(7'd3);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0000);
        send_word(32'h0000_0001);
    endtask

    // Counts above the store size clamp to it; writes abort the runs in progress.
    task automatic test_large_counts();
        set_element_count(7'd127);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_003F);
        send_word(32'h0000_0040);
        send_word(32'h5555_5555);
        set_element_count(7'd65);
        send_word(32'hAAAA_AAAA);
        send_word(32'h0000_0000);
        send_word(32'h7FFF_FFFF);
        set_element_count(7'd64);
        send_word(32'hFFFF_FFFE);
        send_word(32'h0000_0001);
    endtask

    task automatic test_random_runs();
        int unsigned        first_item;
        int unsigned        steps;
        logic [COUNT_W-1:0] count;
        logic [WORD_W-1:0]  word;
        first_item = items_sent;
        while (items_sent - first_item < 730) begin
            case ($urandom_range(0, 9))
                0:       count = COUNT_W'($urandom_range(0, 1));
                1:       count = COUNT_W'(SHUFFLE_SIZE);
                2:       count = COUNT_W'($urandom_range(65, 127));
                3, 4:    count = COUNT_W'($urandom_range(17, 63));
                default: count = COUNT_W'($urandom_range(2, 16));
            endcase
            set_element_count(count);
            repeat ($urandom_range(1, 3)) begin
                steps = active_count() - 1;
                // Now and then a run is cut short and the next one picks up its state.
                if ($urandom_range(0, 5) == 0)
                    steps = $urandom_range(1, steps);
                repeat (steps) begin
                    case ($urandom_range(0, 7))
                        0:       word = '0;
                        1:       word = '1;
                        2:       word = $urandom_range(0, 127);
                        default: word = $urandom;
                    endcase
                    send_word(word);
                end
            end
        end
    endtask

    initial begin
        aresetn           = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_element_count = '0;
        s_tvalid          = 1'b0;
        s_tdata           = '0;
        items_sent        = 0;
        burst_left        = 0;
        count_model       = COUNT_RESET;
        restart_order();

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_count();
        test_small_counts();
        test_large_counts();
        test_random_runs();

        wait_for_results();
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0 && expected_placements.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
